// ----- hw/rtl/mpt_pkg.sv -----
// ---------------------------------------------------------------------------
// mpt_pkg: shared constants for the multichannel period tachometer
// Field widths, register indexes, request codes and reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpt_pkg;

    // Request field widths
    localparam int OP_W      = 2;
    localparam int CHAN_W    = 2;
    localparam int CAPTURE_W = 16;
    localparam int NOW_W     = 32;

    // Configuration widths
    localparam int NUM_W     = 20;
    localparam int WEIGHT_W  = 17;
    localparam int TIMEOUT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // Per-channel state widths
    localparam int OVF_W     = 8;
    // 17-bit weight * 255 overflows + difference stays below 2^25
    localparam int PERIOD_W  = 25;
    localparam int FRAC_W    = 8;
    localparam int FREQ_W    = 28;
    // numerator * 256 + period / 2 needs one bit more than the frequency
    localparam int DIVD_W    = NUM_W + FRAC_W + 1;
    localparam int DCNT_W    = $clog2(DIVD_W + 1);

    localparam logic [OVF_W-1:0]  OVF_MAX  = '1;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    // Request codes
    localparam logic [OP_W-1:0] OP_CAPTURE  = 2'd0;
    localparam logic [OP_W-1:0] OP_OVERFLOW = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP      = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_NUM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVF_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

    // Register reset values
    localparam logic [NUM_W-1:0]     RST_FREQ_NUM   = 20'd100000;
    localparam logic [WEIGHT_W-1:0]  RST_OVF_WEIGHT = 17'd65535;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 16'd40;

endpackage

`default_nettype wire

// ----- hw/rtl/multichannel_period_tachometer.sv -----
// ---------------------------------------------------------------------------
// multichannel_period_tachometer: input-capture period and frequency meter
// Captures form per-channel periods; a sample request walks the channels,
// turns fresh periods into Q.8 frequencies and zeroes timed-out channels.
// ---------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  request  | i_in_valid / o_in_stall   | i_op, i_channel, i_capture_value,
//           |                           | i_now_ms
//  result   | o_out_valid / i_out_stall | o_out_channel, o_frequency_q8,
//           |                           | o_is_stale, o_last
//  config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  Overflow completes as it is accepted; a capture also passes the capture
//  state. A sample walks each channel through scan, check and emit, with the
//  divide and a write-back between when the period is fresh and nonzero
//  (one shared restoring divider, one quotient bit per cycle over 29 bits).
//  Each result waits in the output register until taken; one request is
//  worked at a time and o_in_stall stays high until it is done.
//  Reset is synchronous, active low, and clears all channel state.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_period_tachometer #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // request channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  [mpt_pkg::OP_W-1:0]           i_op,
    input  wire  [mpt_pkg::CHAN_W-1:0]         i_channel,
    input  wire  [mpt_pkg::CAPTURE_W-1:0]      i_capture_value,
    input  wire  [mpt_pkg::NOW_W-1:0]          i_now_ms,
    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [mpt_pkg::CHAN_W-1:0]         o_out_channel,
    output logic [mpt_pkg::FREQ_W-1:0]         o_frequency_q8,
    output logic                               o_is_stale,
    output logic                               o_last,
    // configuration write port
    input  wire                                i_cfg_we,
    input  wire  [mpt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [mpt_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PW   = mpt_pkg::PERIOD_W;
    localparam int DW   = mpt_pkg::DIVD_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CAPT  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state;

    // Configuration registers
    logic [mpt_pkg::NUM_W-1:0]     r_freq_num;
    logic [mpt_pkg::WEIGHT_W-1:0]  r_ovf_weight;
    logic [mpt_pkg::TIMEOUT_W-1:0] r_timeout;

    // Per-channel state
    logic [mpt_pkg::CAPTURE_W-1:0] r_prev   [NUM_CHANNELS];
    logic [mpt_pkg::OVF_W-1:0]     r_ovf    [NUM_CHANNELS];
    logic [PW-1:0]                 r_period [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]       r_fresh;
    logic [mpt_pkg::NOW_W-1:0]     r_stamp  [NUM_CHANNELS];
    logic [mpt_pkg::FREQ_W-1:0]    r_freq   [NUM_CHANNELS];

    // Request and working registers
    logic [CH_W-1:0]               r_ch;
    logic [CH_W-1:0]               r_idx;
    logic [mpt_pkg::CAPTURE_W-1:0] r_cur;
    logic [mpt_pkg::NOW_W-1:0]     r_now;
    logic [PW-1:0]                 r_div;
    logic [PW-1:0]                 r_rem;
    logic [DW-1:0]                 r_quo;
    logic [mpt_pkg::DCNT_W-1:0]    r_cnt;

    // Output registers
    logic                          r_out_valid;
    logic [mpt_pkg::CHAN_W-1:0]    r_out_channel;
    logic [mpt_pkg::FREQ_W-1:0]    r_out_freq;
    logic                          r_out_stale;
    logic                          r_out_last;

    logic                          in_acc;
    logic                          ch_ok;
    logic                          idx_last;

    // Capture datapath
    logic [mpt_pkg::CAPTURE_W-1:0] prev_sel;
    logic [mpt_pkg::OVF_W-1:0]     ovf_sel;
    logic                          cap_take;
    logic [PW:0]                   cap_prod;
    logic [PW:0]                   cap_sum;
    logic [PW-1:0]                 n_period;

    // Divider datapath
    logic [PW-1:0]                 per_sel;
    logic [DW-1:0]                 div_dividend;
    logic [PW:0]                   n_rem_sh;
    logic [PW:0]                   n_rem_sub;
    logic                          n_ge;
    logic [mpt_pkg::FREQ_W-1:0]    n_freq;

    // Staleness check
    logic [mpt_pkg::NOW_W-1:0]     age;
    logic                          n_stale;

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_acc         = i_in_valid && !o_in_stall;
    assign ch_ok          = (int'(i_channel) < NUM_CHANNELS);
    assign idx_last       = (int'(r_idx) == NUM_CHANNELS - 1);

    assign o_out_valid    = r_out_valid;
    assign o_out_channel  = r_out_channel;
    assign o_frequency_q8 = r_out_freq;
    assign o_is_stale     = r_out_stale;
    assign o_last         = r_out_last;

    // Period from previous capture, overflow count and weight
    always_comb begin
        prev_sel = r_prev[r_ch];
        ovf_sel  = r_ovf[r_ch];
        cap_take = (prev_sel != '0) && (r_cur > prev_sel);
        cap_prod = (PW+1)'(r_ovf_weight) * (PW+1)'(ovf_sel);
        cap_sum  = cap_prod + (PW+1)'(r_cur - prev_sel);
        n_period = cap_sum[PW-1:0];
    end

    // One restoring division step per cycle, divisor in r_div
    always_comb begin
        per_sel      = r_period[r_idx];
        div_dividend = DW'({r_freq_num, {mpt_pkg::FRAC_W{1'b0}}})
                     + DW'(per_sel >> 1);
        n_rem_sh     = {r_rem, r_quo[DW-1]};
        n_ge         = (n_rem_sh >= {1'b0, r_div});
        n_rem_sub    = n_rem_sh - {1'b0, r_div};
        n_freq       = r_quo[DW-1] ? mpt_pkg::FREQ_MAX : r_quo[mpt_pkg::FREQ_W-1:0];
    end

    // Age of the channel's stamp against the timeout
    always_comb begin
        age     = r_now - r_stamp[r_idx];
        n_stale = (age > mpt_pkg::NOW_W'(r_timeout));
    end

    // Control, configuration and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_freq_num   <= mpt_pkg::RST_FREQ_NUM;
            r_ovf_weight <= mpt_pkg::RST_OVF_WEIGHT;
            r_timeout    <= mpt_pkg::RST_TIMEOUT;
            r_fresh      <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_cnt        <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_prev[i]   <= '0;
                r_ovf[i]    <= '0;
                r_period[i] <= '0;
                r_stamp[i]  <= '0;
                r_freq[i]   <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mpt_pkg::REG_FREQ_NUM:   r_freq_num   <= i_cfg_data[mpt_pkg::NUM_W-1:0];
                    mpt_pkg::REG_OVF_WEIGHT: r_ovf_weight <= i_cfg_data[mpt_pkg::WEIGHT_W-1:0];
                    mpt_pkg::REG_TIMEOUT:    r_timeout    <= i_cfg_data[mpt_pkg::TIMEOUT_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_op)
                            mpt_pkg::OP_CAPTURE: begin
                                if (ch_ok) r_state <= S_CAPT;
                            end
                            mpt_pkg::OP_OVERFLOW: begin
                                // saturating increment on every channel
                                for (int i = 0; i < NUM_CHANNELS; i++) begin
                                    if (r_ovf[i] != mpt_pkg::OVF_MAX)
                                        r_ovf[i] <= r_ovf[i] + 1'b1;
                                end
                            end
                            mpt_pkg::OP_SAMPLE: begin
                                r_idx   <= '0;
                                r_state <= S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CAPT: begin
                    if (cap_take) begin
                        r_period[r_ch] <= n_period;
                        r_fresh[r_ch]  <= 1'b1;
                    end
                    r_prev[r_ch] <= r_cur;
                    r_ovf[r_ch]  <= '0;
                    r_state      <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_fresh[r_idx]) begin
                        if (per_sel == '0) begin
                            // no period: frequency reads zero
                            r_freq[r_idx]  <= '0;
                            r_stamp[r_idx] <= r_now;
                            r_fresh[r_idx] <= 1'b0;
                            r_state        <= S_CHECK;
                        end else begin
                            r_cnt   <= mpt_pkg::DCNT_W'(DW);
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == mpt_pkg::DCNT_W'(1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_freq[r_idx]  <= n_freq;
                    r_stamp[r_idx] <= r_now;
                    r_fresh[r_idx] <= 1'b0;
                    r_state        <= S_CHECK;
                end
                S_CHECK: begin
                    if (n_stale) r_freq[r_idx] <= '0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (idx_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload and divider registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_ch  <= CH_W'(i_channel);
            r_cur <= i_capture_value;
            r_now <= i_now_ms;
        end
        if (r_state == S_SCAN) begin
            r_div <= per_sel;
            r_rem <= '0;
            r_quo <= div_dividend;
        end else if (r_state == S_DIV) begin
            r_rem <= n_ge ? n_rem_sub[PW-1:0] : n_rem_sh[PW-1:0];
            r_quo <= {r_quo[DW-2:0], n_ge};
        end
        if (r_state == S_CHECK) begin
            r_out_channel <= mpt_pkg::CHAN_W'(r_idx);
            r_out_freq    <= n_stale ? '0 : r_freq[r_idx];
            r_out_stale   <= n_stale;
            r_out_last    <= idx_last;
        end
    end

endmodule

`default_nettype wire

// ----- test/multichannel_period_tachometer_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multichannel_period_tachometer_test: self-checking bench for the tachometer
// Drives capture, overflow, sample and idle requests with random gaps and
// stalls, predicts every per-channel reading, and checks each one in order
// across several register settings, the extremes among them.
// ---------------------------------------------------------------------------

import mpt_pkg::*;

localparam int TACH_CHANNELS = 4;

typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [FREQ_W-1:0] freq;
    logic              stale;
    logic              last;
} tach_reading_t;

// Predicts the tachometer readings and checks the ones the block returns
class tach_scoreboard;
    logic [NUM_W-1:0]     freq_num;
    logic [WEIGHT_W-1:0]  ovf_weight;
    logic [TIMEOUT_W-1:0] timeout;

    logic [CAPTURE_W-1:0] prior_capture [TACH_CHANNELS];
    logic [OVF_W-1:0]     ovf_count     [TACH_CHANNELS];
    logic [31:0]          period        [TACH_CHANNELS];
    bit                   fresh         [TACH_CHANNELS];
    logic [NOW_W-1:0]     stamp         [TACH_CHANNELS];
    logic [FREQ_W-1:0]    freq          [TACH_CHANNELS];

    tach_reading_t expected_readings [$];
    int errors, checked, samples, captures, overflows;

    function new();
        freq_num   = RST_FREQ_NUM;
        ovf_weight = RST_OVF_WEIGHT;
        timeout    = RST_TIMEOUT;
        for (int c = 0; c < TACH_CHANNELS; c++) begin
            prior_capture[c] = '0;
            ovf_count[c]     = '0;
            period[c]        = '0;
            fresh[c]         = 1'b0;
            stamp[c]         = '0;
            freq[c]          = '0;
        end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_FREQ_NUM:   freq_num   = data[NUM_W-1:0];
            REG_OVF_WEIGHT: ovf_weight = data[WEIGHT_W-1:0];
            REG_TIMEOUT:    timeout    = data[TIMEOUT_W-1:0];
            default: ;
        endcase
    endfunction

    // Q.8 frequency, rounded to nearest, saturated
    function logic [FREQ_W-1:0] period_to_freq(logic [31:0] p);
        longint unsigned q;
        longint unsigned num64;
        longint unsigned p64;
        if (p == 0)
            return '0;
        num64 = freq_num;
        p64   = p;
        q = (num64 * 256 + (p64 >> 1)) / p64;
        if (q > FREQ_MAX)
            return FREQ_MAX;
        return q[FREQ_W-1:0];
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [CHAN_W-1:0] ch,
                               logic [CAPTURE_W-1:0] cap, logic [NOW_W-1:0] now);
        logic [63:0]   p;
        tach_reading_t r;
        case (op)
            OP_CAPTURE: begin
                captures++;
                if (ch < TACH_CHANNELS) begin
                    if (prior_capture[ch] != 0 && cap > prior_capture[ch]) begin
                        p = 64'(ovf_weight) * 64'(ovf_count[ch])
                            + 64'(cap - prior_capture[ch]);
                        period[ch] = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
                        fresh[ch]  = 1'b1;
                    end
                    prior_capture[ch] = cap;
                    ovf_count[ch]     = '0;
                end
            end
            OP_OVERFLOW: begin
                overflows++;
                for (int c = 0; c < TACH_CHANNELS; c++)
                    if (ovf_count[c] < OVF_MAX)
                        ovf_count[c]++;
            end
            OP_SAMPLE: begin
                samples++;
                for (int c = 0; c < TACH_CHANNELS; c++) begin
                    r.stale = 1'b0;
                    if (fresh[c]) begin
                        freq[c]  = period_to_freq(period[c]);
                        stamp[c] = now;
                        fresh[c] = 1'b0;
                    end
                    // wrapping age compare
                    if (now - stamp[c] > 32'(timeout)) begin
                        freq[c] = '0;
                        r.stale = 1'b1;
                    end
                    r.chan = CHAN_W'(c);
                    r.freq = freq[c];
                    r.last = (c == TACH_CHANNELS - 1);
                    expected_readings.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_readings.size();
    endfunction

    // Print is capped so a broken block cannot flood the log
    task report(string msg);
        if (errors < 40)
            $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic [CHAN_W-1:0] chan, logic [FREQ_W-1:0] f,
                      logic stale, logic last);
        tach_reading_t e;
        if (expected_readings.size() == 0) begin
            report($sformatf("unexpected reading ch %0d freq %0d", chan, f));
            return;
        end
        e = expected_readings.pop_front();
        checked++;
        if (chan !== e.chan)
            report($sformatf("channel %0d, want %0d", chan, e.chan));
        if (f !== e.freq)
            report($sformatf("ch %0d frequency %0d, want %0d", e.chan, f, e.freq));
        if (stale !== e.stale)
            report($sformatf("ch %0d stale %b, want %b", e.chan, stale, e.stale));
        if (last !== e.last)
            report($sformatf("ch %0d last %b, want %b", e.chan, last, e.last));
    endtask
endclass

module multichannel_period_tachometer_test;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op;
    logic [CHAN_W-1:0]    i_channel;
    logic [CAPTURE_W-1:0] i_capture_value;
    logic [NOW_W-1:0]     i_now_ms;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [CHAN_W-1:0]    o_out_channel;
    logic [FREQ_W-1:0]    o_frequency_q8;
    logic                 o_is_stale;
    logic                 o_last;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    tach_scoreboard       sb;
    int                   cycle_count = 0;
    int                   hold_left   = 0;
    int                   settings    = 1;
    bit                   steady      = 1'b0;
    logic [NOW_W-1:0]     clock_ms    = '0;
    logic [CAPTURE_W-1:0] recent_capture [TACH_CHANNELS];

    multichannel_period_tachometer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_channel       (i_channel),
        .i_capture_value (i_capture_value),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_channel   (o_out_channel),
        .o_frequency_q8  (o_frequency_q8),
        .o_is_stale      (o_is_stale),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d readings pending",
                     cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Reading side: random stalls, long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !steady && ($urandom_range(99) < 36);
            end
        end
    end

    // Check every accepted reading
    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_channel, o_frequency_q8, o_is_stale, o_last);

    task send_request(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                      input logic [CAPTURE_W-1:0] cap, input logic [NOW_W-1:0] now);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < 36)
                gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_channel       <= ch;
        i_capture_value <= cap;
        i_now_ms        <= now;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(op, ch, cap, now);
        if (op == OP_CAPTURE)
            recent_capture[ch] = cap;
    endtask

    // Advance the millisecond clock around the timeout, sometimes jump anywhere
    task send_sample();
        if ($urandom_range(9) == 0)
            clock_ms = $urandom;
        else
            clock_ms += $urandom_range(0, 2 * sb.timeout + 2);
        send_request(OP_SAMPLE, CHAN_W'($urandom), CAPTURE_W'($urandom), clock_ms);
    endtask

    task random_request();
        int                   pick;
        logic [CHAN_W-1:0]    ch;
        logic [CAPTURE_W-1:0] cap;
        pick = $urandom_range(99);
        ch   = CHAN_W'($urandom);
        if (pick < 40) begin
            case ($urandom_range(19))
                0:       cap = '0;
                1:       cap = recent_capture[ch];
                2, 3:    cap = CAPTURE_W'($urandom);
                default: begin
                    // mostly a rising edge train; restart low near the top
                    if (recent_capture[ch] > 16'hFFFF - 4000)
                        cap = CAPTURE_W'($urandom_range(1, 200));
                    else
                        cap = recent_capture[ch] + CAPTURE_W'($urandom_range(1, 4000));
                end
            endcase
            send_request(OP_CAPTURE, ch, cap, $urandom);
        end else if (pick < 60) begin
            send_request(OP_OVERFLOW, ch, CAPTURE_W'($urandom), $urandom);
        end else if (pick < 94) begin
            send_sample();
        end else begin
            send_request(OP_NOP, ch, CAPTURE_W'($urandom), $urandom);
        end
    endtask

    task run_random(input int count);
        repeat (count) random_request();
    endtask

    // Stop offering and wait for every predicted reading
    task wait_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Idle the block: captures and overflows leave no reading to wait for
    task drain();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    task apply_settings(input logic [CFG_DAT_W-1:0] num, input logic [CFG_DAT_W-1:0] weight,
                        input logic [CFG_DAT_W-1:0] tmo);
        drain();
        write_register(REG_FREQ_NUM, num);
        write_register(REG_OVF_WEIGHT, weight);
        write_register(REG_TIMEOUT, tmo);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        sb              = new();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_op            = OP_NOP;
        i_channel       = '0;
        i_capture_value = '0;
        i_now_ms        = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        for (int c = 0; c < TACH_CHANNELS; c++)
            recent_capture[c] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values
        send_request(OP_SAMPLE,   2'd0, 16'h0000, 32'd0);
        send_request(OP_CAPTURE,  2'd0, 16'h0000, 32'd0);    // zero capture, no previous
        send_request(OP_CAPTURE,  2'd0, 16'd100,  32'd0);    // previous was zero
        send_request(OP_CAPTURE,  2'd0, 16'd1100, 32'd0);    // period 1000
        send_request(OP_CAPTURE,  2'd1, 16'hFFFF, 32'd0);
        send_request(OP_CAPTURE,  2'd1, 16'hFFFF, 32'd0);    // equal, not larger
        send_request(OP_CAPTURE,  2'd1, 16'd5,    32'd0);    // smaller
        send_request(OP_OVERFLOW, 2'd3, 16'h0000, 32'd0);
        send_request(OP_OVERFLOW, 2'd0, 16'h0000, 32'd0);
        send_request(OP_CAPTURE,  2'd1, 16'd6,    32'd0);    // two overflows plus one
        send_request(OP_CAPTURE,  2'd2, 16'd1,    32'd0);
        send_request(OP_CAPTURE,  2'd2, 16'hFFFF, 32'd0);    // widest difference
        send_request(OP_CAPTURE,  2'd3, 16'h8000, 32'd0);
        send_request(OP_NOP,      2'd3, 16'h7FFF, 32'hFFFF_FFFF);
        send_request(OP_CAPTURE,  2'd3, 16'h8001, 32'd0);    // one-tick period
        send_request(OP_SAMPLE,   2'd0, 16'h0000, 32'd10);
        send_request(OP_SAMPLE,   2'd0, 16'h0000, 32'd50);   // age equals timeout
        send_request(OP_SAMPLE,   2'd0, 16'h0000, 32'd51);   // just past timeout
        send_request(OP_SAMPLE,   2'd0, 16'h0000, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FFF0;                            // next samples wrap
        run_random(16);

        // Large register values, top of the timeout range, overflow count saturation
        apply_settings(20'd1000000, 20'd65536, 20'd65535);
        send_request(OP_CAPTURE, 2'd0, 16'd1, 32'd0);
        repeat (256)
            send_request(OP_OVERFLOW, 2'd2, CAPTURE_W'($urandom), $urandom);
        send_request(OP_CAPTURE, 2'd0, 16'hFFFF, 32'd0);
        send_sample();
        run_random(16);

        // Reader holds off while samples keep coming
        wait_results();
        hold_left = HOLD_CYCLES;
        repeat (6) send_sample();
        wait_results();

        // Lowest nonzero register values, no idling on either side
        apply_settings(20'd1, 20'd1, 20'd1);
        steady = 1'b1;
        run_random(12);
        steady = 1'b0;

        // All zero, plus a write to the unused index
        apply_settings(20'd0, 20'd0, 20'd0);
        write_register(REG_UNUSED, CFG_DAT_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        run_random(12);

        // Every data bit high
        apply_settings(20'hFFFFF, 20'h1FFFF, 20'hFFFF);
        run_random(12);

        apply_settings(CFG_DAT_W'($urandom_range(1, 1000000)),
                       CFG_DAT_W'($urandom_range(1, 65536)),
                       CFG_DAT_W'($urandom_range(1, 200)));
        run_random(12);

        drain();
        $display("Requests: %0d captures, %0d overflows, %0d samples; %0d readings checked",
                 sb.captures, sb.overflows, sb.samples, sb.checked);
        $display("Register settings run: %0d, mismatches: %0d", settings, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mpt_pkg.sv
hw/rtl/multichannel_period_tachometer.sv
test/multichannel_period_tachometer_test.sv
